// ===== hw/rtl/imgc_pkg.sv =====
// Package with the types, codes and constants of the image container check unit.
package imgc_pkg;

  // Parse phase of the container walk.
  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_J_SEARCH = 4'd1,
    PH_J_RUN    = 4'd2,
    PH_J_LENHI  = 4'd3,
    PH_J_LENLO  = 4'd4,
    PH_J_SKIP   = 4'd5,
    PH_P_SIG    = 4'd6,
    PH_P_LEN    = 4'd7,
    PH_P_TYPE   = 4'd8,
    PH_P_BODY   = 4'd9,
    PH_P_END    = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    V_PENDING = 2'd0,
    V_ACCEPT  = 2'd1,
    V_REJECT  = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_JPEG = 2'd1,
    FMT_PNG  = 2'd2
  } fmt_t;

  typedef enum logic [1:0] {
    ST_VALID       = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_FAILED      = 2'd2
  } stat_t;

  localparam logic [3:0]  POS_LIMIT     = 4'd8;
  localparam logic [31:0] PNG_MAGIC     = 32'h8950_4E47;
  localparam logic [31:0] TYPE_IHDR     = 32'h4948_4452;
  localparam logic [31:0] TYPE_IEND     = 32'h4945_4E44;
  localparam logic [31:0] IHDR_LEN      = 32'd13;
  localparam logic [15:0] JPEG_SOI      = 16'hFFD8;
  localparam logic [7:0]  BYTE_FF       = 8'hFF;
  localparam logic [7:0]  MARK_EOI      = 8'hD9;
  localparam logic [7:0]  MARK_SOS      = 8'hDA;
  localparam logic [7:0]  MARK_TEM      = 8'h01;
  localparam logic [7:0]  MARK_RST_LO   = 8'hD0;
  localparam logic [7:0]  MARK_RST_HI   = 8'hD7;
  localparam logic [32:0] FIELD_BYTES   = 33'd4;

  // Byte of the 8-byte PNG signature at a given position.
  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      default: val = 8'h0A;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/image_container_check_unit.sv =====
// Image container check unit: PNG chunk walk and JPEG marker walk over a byte stream.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | to unit   | in_valid, in_stall | data_byte, final_byte
//   out     | from unit | out_valid, out_stall | status, image_format
//
// One byte is taken every cycle while in_stall is low; the walk state is updated in the same cycle.
// The final byte of a file registers its result in the output or skid register.
// Two result registers (output and skid) let bytes keep flowing while a result
// waits; in_stall rises only when both are full.
// Reset (rst, synchronous) returns the walk to the start of a new file.
module image_container_check_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [1:0] image_format
);
  import imgc_pkg::*;

  // Walk state.
  logic [3:0]  byte_position, byte_position_next;
  fmt_t        format_seen, format_seen_next;
  phase_t      parse_phase, parse_phase_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [32:0] bytes_to_skip, bytes_to_skip_next;
  logic        first_chunk_done, first_chunk_done_next;
  verdict_t    verdict, verdict_next;
  logic [7:0]  previous_byte;

  // Result registers.
  logic        skid_valid, skid_valid_next, out_valid_next;
  logic [1:0]  skid_status, skid_format;
  logic [1:0]  res_status, res_format;

  logic        in_fire, out_fire, res_new, ok;
  logic [31:0] shifted;
  logic [32:0] skip_dec;
  logic [15:0] seg_len;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign res_new  = in_fire && final_byte;
  assign in_stall = skid_valid;

  assign shifted  = {field_shift[23:0], data_byte};
  assign skip_dec = bytes_to_skip - 33'd1;
  assign seg_len  = {field_shift[7:0], data_byte};

  always_comb begin
    format_seen_next      = format_seen;
    parse_phase_next      = parse_phase;
    field_shift_next      = field_shift;
    chunk_size_next       = chunk_size;
    bytes_to_skip_next    = bytes_to_skip;
    first_chunk_done_next = first_chunk_done;
    verdict_next          = verdict;

    if (verdict == V_PENDING) begin
      if (parse_phase == PH_HEADER) begin
        field_shift_next = shifted;
        if (byte_position == 4'd1 && shifted[15:0] == JPEG_SOI) begin
          format_seen_next = FMT_JPEG;
          parse_phase_next = PH_J_SEARCH;
        end else if (byte_position == 4'd3) begin
          if (shifted == PNG_MAGIC) begin
            format_seen_next = FMT_PNG;
            parse_phase_next = PH_P_SIG;
          end else begin
            verdict_next = V_REJECT;
          end
        end
      end else if (format_seen == FMT_JPEG) begin
        case (parse_phase)
          PH_J_SEARCH: begin
            if (data_byte == BYTE_FF) parse_phase_next = PH_J_RUN;
          end
          PH_J_RUN: begin
            // Fill bytes (FF runs) keep the phase.
            if (data_byte == BYTE_FF) begin
              parse_phase_next = PH_J_RUN;
            end else if (data_byte == MARK_EOI) begin
              verdict_next = V_REJECT;
            end else if (data_byte == MARK_SOS) begin
              verdict_next = V_ACCEPT;
            end else if (data_byte inside {MARK_TEM, [MARK_RST_LO:MARK_RST_HI]}) begin
              parse_phase_next = PH_J_SEARCH;
            end else begin
              parse_phase_next = PH_J_LENHI;
            end
          end
          PH_J_LENHI: begin
            field_shift_next = {24'd0, data_byte};
            parse_phase_next = PH_J_LENLO;
          end
          PH_J_LENLO: begin
            if (seg_len < 16'd2) begin
              verdict_next = V_REJECT;
            end else begin
              bytes_to_skip_next = {17'd0, seg_len - 16'd2};
              parse_phase_next   = (seg_len != 16'd2) ? PH_J_SKIP : PH_J_SEARCH;
            end
          end
          PH_J_SKIP: begin
            bytes_to_skip_next = skip_dec;
            if (skip_dec == 33'd0) parse_phase_next = PH_J_SEARCH;
          end
          default: begin
            parse_phase_next = parse_phase;
          end
        endcase
      end else begin
        case (parse_phase)
          PH_P_SIG: begin
            if (data_byte != png_sig_byte(byte_position[2:0])) begin
              verdict_next = V_REJECT;
            end else if (byte_position >= 4'd7) begin
              parse_phase_next   = PH_P_LEN;
              bytes_to_skip_next = FIELD_BYTES;
              field_shift_next   = 32'd0;
            end
          end
          PH_P_LEN: begin
            field_shift_next   = shifted;
            bytes_to_skip_next = skip_dec;
            if (skip_dec == 33'd0) begin
              chunk_size_next    = shifted;
              parse_phase_next   = PH_P_TYPE;
              bytes_to_skip_next = FIELD_BYTES;
            end
          end
          PH_P_TYPE: begin
            field_shift_next   = shifted;
            bytes_to_skip_next = skip_dec;
            if (skip_dec == 33'd0) begin
              if (!first_chunk_done &&
                  (shifted != TYPE_IHDR || chunk_size != IHDR_LEN)) begin
                verdict_next = V_REJECT;
              end else begin
                first_chunk_done_next = 1'b1;
                if (shifted == TYPE_IEND) begin
                  if (chunk_size != 32'd0) begin
                    verdict_next = V_REJECT;
                  end else begin
                    parse_phase_next   = PH_P_END;
                    bytes_to_skip_next = FIELD_BYTES;
                  end
                end else begin
                  // Chunk body plus its 4-byte CRC.
                  parse_phase_next   = PH_P_BODY;
                  bytes_to_skip_next = {1'b0, chunk_size} + FIELD_BYTES;
                end
              end
            end
          end
          PH_P_BODY: begin
            bytes_to_skip_next = skip_dec;
            if (skip_dec == 33'd0) begin
              parse_phase_next   = PH_P_LEN;
              bytes_to_skip_next = FIELD_BYTES;
              field_shift_next   = 32'd0;
            end
          end
          PH_P_END: begin
            bytes_to_skip_next = skip_dec;
            if (skip_dec == 33'd0) verdict_next = final_byte ? V_ACCEPT : V_REJECT;
          end
          default: begin
            parse_phase_next = parse_phase;
          end
        endcase
      end
    end

    byte_position_next = (byte_position < POS_LIMIT) ? byte_position + 4'd1 : byte_position;

    ok = (verdict_next == V_ACCEPT) &&
         (format_seen_next != FMT_JPEG ||
          (previous_byte == BYTE_FF && data_byte == MARK_EOI));
    if (byte_position_next < POS_LIMIT || format_seen_next == FMT_NONE) begin
      res_status = ST_UNSUPPORTED;
      res_format = FMT_NONE;
    end else begin
      res_status = ok ? ST_VALID : ST_FAILED;
      res_format = format_seen_next;
    end
  end

  // Control state of the walk; a final byte starts the next file afresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 4'd0;
      format_seen      <= FMT_NONE;
      parse_phase      <= PH_HEADER;
      first_chunk_done <= 1'b0;
      verdict          <= V_PENDING;
    end else if (in_fire) begin
      if (final_byte) begin
        byte_position    <= 4'd0;
        format_seen      <= FMT_NONE;
        parse_phase      <= PH_HEADER;
        first_chunk_done <= 1'b0;
        verdict          <= V_PENDING;
      end else begin
        byte_position    <= byte_position_next;
        format_seen      <= format_seen_next;
        parse_phase      <= parse_phase_next;
        first_chunk_done <= first_chunk_done_next;
        verdict          <= verdict_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_shift   <= 32'd0;
      chunk_size    <= 32'd0;
      bytes_to_skip <= 33'd0;
      previous_byte <= 8'd0;
    end else if (in_fire) begin
      field_shift   <= field_shift_next;
      chunk_size    <= chunk_size_next;
      bytes_to_skip <= bytes_to_skip_next;
      previous_byte <= data_byte;
    end
  end

  // Output register with a skid slot behind it.
  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    if (out_fire || !out_valid) begin
      out_valid_next  = skid_valid || res_new;
      skid_valid_next = 1'b0;
    end else if (res_new) begin
      skid_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        status       <= skid_status;
        image_format <= skid_format;
      end else if (res_new) begin
        status       <= res_status;
        image_format <= res_format;
      end
    end else if (res_new) begin
      skid_status <= res_status;
      skid_format <= res_format;
    end
  end

  // The skid slot is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a result while the output register is empty");

  a_valid_has_format: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_VALID) |-> (image_format == FMT_JPEG || image_format == FMT_PNG))
    else $error("valid status without a known format");

  a_unsup_no_format: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_UNSUPPORTED) |-> image_format == FMT_NONE)
    else $error("unsupported status with a format");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LIMIT)
    else $error("byte position past its limit");

  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    res_new |=> (byte_position == 4'd0 && verdict == V_PENDING && parse_phase == PH_HEADER))
    else $error("walk not restarted after the final byte");

endmodule
